[design/assert_macros.svh]
// Assertion macros used by the indexer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent property check, sampled on the rising edge, off while in reset.
`define VTDI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition in one cycle implies a consequence in the next.
`define VTDI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VTDI_ASSERT(lbl, clk, rst_n, prop, msg)
`define VTDI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[design/vtdi_pkg.sv]
// Package for the vertex triplet indexer: sizes and the query record.
package vtdi_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int INDEX_BITS    = 20;
    localparam int POS_BITS      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS      = $clog2(TABLE_DEPTH + 1);

    localparam int FIELD_BITS    = 20;
    localparam int FACE_BITS     = 10;
    localparam int IN_DATA_BITS  = ((3 * FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((FACE_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS = 2;

    // Query travelling down the cell row.
    typedef struct packed {
        logic                  busy;    // slot holds a corner
        logic                  done;    // matched or stored already
        logic                  is_new;  // stored as a new entry
        logic [POS_BITS-1:0]   slot;    // table position once done
        logic [INDEX_BITS-1:0] vtx;
        logic [INDEX_BITS-1:0] uv;
        logic [INDEX_BITS-1:0] nrm;
    } t_query;

endpackage

[design/vtdi_cell.sv]
// One table cell: holds one triplet, compares the passing query, stores at the tail.
module vtdi_cell
    import vtdi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [POS_BITS-1:0] i_pos,
    input  logic [CNT_BITS-1:0] i_count,
    input  t_query              i_q,
    output t_query              o_q,
    output logic                o_ins
);

    logic [INDEX_BITS-1:0] r_vtx;
    logic [INDEX_BITS-1:0] r_uv;
    logic [INDEX_BITS-1:0] r_nrm;
    t_query                r_q;
    t_query                n_q;
    logic                  w_live;
    logic                  w_tail;
    logic                  w_hit;
    logic                  w_ins;

    // A pending query never sits past the tail, so every cell it meets is
    // either filled or is the tail itself.
    always_comb begin
        w_live = i_q.busy && !i_q.done;
        w_tail = (CNT_BITS'(i_pos) == i_count);
        w_hit  = w_live && !w_tail && (r_vtx == i_q.vtx) && (r_uv == i_q.uv)
                 && (r_nrm == i_q.nrm);
        w_ins  = w_live && w_tail;
        n_q    = i_q;
        if (w_hit || w_ins) begin
            n_q.done   = 1'b1;
            n_q.slot   = i_pos;
            n_q.is_new = w_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.busy <= 1'b0;
        end else if (i_adv) begin
            r_q <= n_q;
        end
        if (i_adv && w_ins) begin
            r_vtx <= i_q.vtx;
            r_uv  <= i_q.uv;
            r_nrm <= i_q.nrm;
        end
    end

    assign o_q   = r_q;
    assign o_ins = i_adv && w_ins;

endmodule

[design/vertex_triplet_dedup_indexer.sv]
// Top level of the vertex triplet indexer: input stage, cell row, count and output register.
//
// Input channel (i_s_*): one face corner per transfer, three indices packed in
// i_s_tdata. Output channel (o_m_*): one result per corner, in input order:
// face_index in o_m_tdata, is_new and table_full in o_m_tuser.
// The corner walks a row of TABLE_DEPTH cells, one cell per cycle while the row advances;
// each cell holds one stored triplet and compares it with the corner as it passes. The
// first cell whose triplet matches fixes the position; the cell at the tail
// stores an unmatched corner. With every cell filled, the result is index 0 with
// table_full set and nothing is stored.
// The result is registered in each cell of the row in turn and then in the output
// register. A new corner can enter every cycle while the row advances, as
// later corners trail earlier ones down the row and see their inserts.
// Reset empties the table (entry count to zero) and drops any corner in flight.
// When the receiver stalls with a result held in the output register, the whole
// row freezes and o_s_tready falls until the result is taken.
module vertex_triplet_dedup_indexer
    import vtdi_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,   // vertex_index, uv_index, normal_index, pad
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,   // face_index, pad
    output logic [OUT_USER_BITS-1:0] o_m_tuser    // is_new, table_full
);

`include "assert_macros.svh"

    t_query                 w_q [TABLE_DEPTH+1];
    t_query                 w_head;
    logic [TABLE_DEPTH-1:0] w_ins;
    logic                   w_adv;
    logic [CNT_BITS-1:0]    r_count;
    logic                   r_out_valid;
    logic [FACE_BITS-1:0]   r_face;
    logic                   r_is_new;
    logic                   r_full;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = w_adv;

    always_comb begin
        w_head.busy   = i_s_tvalid;
        w_head.done   = 1'b0;
        w_head.is_new = 1'b0;
        w_head.slot   = '0;
        w_head.vtx    = INDEX_BITS'(i_s_tdata[FIELD_BITS-1:0]);
        w_head.uv     = INDEX_BITS'(i_s_tdata[2*FIELD_BITS-1:FIELD_BITS]);
        w_head.nrm    = INDEX_BITS'(i_s_tdata[3*FIELD_BITS-1:2*FIELD_BITS]);
    end

    assign w_q[0] = w_head;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        vtdi_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_pos   (POS_BITS'(g)),
            .i_count (r_count),
            .i_q     (w_q[g]),
            .o_q     (w_q[g+1]),
            .o_ins   (w_ins[g])
        );
    end

    // Only the tail cell can store, so at most one insert per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (|w_ins) begin
            r_count <= r_count + CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_q[TABLE_DEPTH].busy;
        end
    end

    // A corner that reaches the end still pending found neither match nor room.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_face   <= w_q[TABLE_DEPTH].done ? FACE_BITS'(w_q[TABLE_DEPTH].slot) : '0;
            r_is_new <= w_q[TABLE_DEPTH].done && w_q[TABLE_DEPTH].is_new;
            r_full   <= !w_q[TABLE_DEPTH].done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_BITS'(r_face);
    assign o_m_tuser  = {r_full, r_is_new};

    `VTDI_ASSERT(a_count_bound, i_clk, i_rst_n, (r_count <= CNT_BITS'(TABLE_DEPTH)), "entry count beyond table depth")
    `VTDI_ASSERT(a_single_insert, i_clk, i_rst_n, $onehot0(w_ins), "more than one cell stored in a cycle")
    `VTDI_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, (|w_ins), (r_count == $past(r_count) + CNT_BITS'(1)), "insert did not advance the entry count")
    `VTDI_ASSERT(a_full_only_when_full, i_clk, i_rst_n, ((r_out_valid && r_full) |-> (r_count == CNT_BITS'(TABLE_DEPTH))), "table_full reported with free entries")

endmodule
